// File: rtl/core/lazy_pointer_leash_smoother_macros.svh
// Assertion macros shared by the checker.
`ifndef LAZY_POINTER_LEASH_SMOOTHER_MACROS_SVH
`define LAZY_POINTER_LEASH_SMOOTHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LPLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LPLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/lpls_pkg.sv
// ----------------------------------------------------------------------------
// lpls_pkg
// Types and constants for the leash smoother.
// ----------------------------------------------------------------------------
package lpls_pkg;
    localparam int CW = 32;
    localparam int RADIUS_W = 23;
    localparam int WEIGHT_W = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_BYPASS = 23'd655;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'd62259;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd196608;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd32768;

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_RESET  = 2'd1,
        CMD_SETPOS = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_RADIUS = 1'b0,
        REG_WEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [31:0]    target_x;
        logic [31:0]    target_y;
        logic [7:0]     buttons;
    } in_word_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
    } out_word_t;

    // start of an iterative job
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [65:0] num;
        logic [32:0] den;
    } job_t;
endpackage

// File: rtl/core/lazy_pointer_leash_smoother.sv
// ----------------------------------------------------------------------------
// lazy_pointer_leash_smoother
// Radius follower with exponential smoothing for pen reports, Q15.16.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_word  (cmd, target_x/y, buttons)
//  out     | out_valid / out_ready  | out_word (pos_x, pos_y)
//  cfg     | cfg_we                 | cfg_idx, cfg_data
//
// A tracking report runs the square root and, when the distance exceeds the
// radius, the two axis divides (set up, one bit per cycle, then collected),
// all on the one shared serial unit, plus the steps DIFF, SQ, CMP, MULX, MULY,
// BLX and BLY. Snap, bypass and commands go from S_IDLE straight to S_OUT.
// Reset loads default radius and weight; position and leash start at zero.
// The input is held off while an item is in work; one finished result may
// wait in the output register, and the next item stalls at its end until then.
module lazy_pointer_leash_smoother (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpls_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lpls_pkg::out_word_t  out_word,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [22:0]          cfg_data
);
    import lpls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ, S_SQRT, S_CMP, S_MULX, S_DIVX, S_MULY, S_DIVY,
        S_BLX, S_BLY, S_OUT
    } state_t;

    state_t state_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic signed [31:0] sx_reg, sy_reg, lx_reg, ly_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic latched_reg, ptip_reg, tip_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [65:0] acc_reg;
    logic [32:0] dist_reg;
    logic [32:0] excess_reg;
    logic        unit_started_reg;
    job_t        job;
    logic        unit_busy;
    logic [32:0] unit_q;
    out_word_t   out_reg;
    logic        ovalid_reg;

    // shared operand mux for the squaring and scaling multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] mag_dx, mag_dy;
    logic signed [32:0] dxw, dyw;
    logic signed [31:0] dx_sat, dy_sat;
    logic [15:0] wa;
    logic signed [49:0] blend_s;
    logic signed [31:0] blend_r;
    logic signed [32:0] mv_sum;
    logic signed [31:0] mv_sat;
    logic signed [31:0] bl_p, bl_c;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    assign mag_dx = dx_reg[31] ? 32'(-dx_reg) : dx_reg;
    assign mag_dy = dy_reg[31] ? 32'(-dy_reg) : dy_reg;
    assign dxw = 33'(tx_reg) - 33'(lx_reg);
    assign dyw = 33'(ty_reg) - 33'(ly_reg);
    assign dx_sat = sat33(dxw);
    assign dy_sat = sat33(dyw);
    assign wa = (weight_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_reg;

    always_comb
    begin
        unique case (state_reg)
            S_SQ:    begin mul_a = mag_dx; mul_b = mag_dx; end
            S_CMP:   begin mul_a = mag_dy; mul_b = mag_dy; end
            S_MULX:  begin mul_a = mag_dx; mul_b = excess_reg[31:0]; end
            S_MULY:  begin mul_a = mag_dy; mul_b = excess_reg[31:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // blend: p*a + c*(65536-a) + 32768, floor shift by 16
    assign bl_p = (state_reg == S_BLX) ? sx_reg : sy_reg;
    assign bl_c = (state_reg == S_BLX) ? lx_reg : ly_reg;
    assign blend_s = 50'(bl_p) * $signed({1'b0, wa})
                   + 50'(bl_c) * $signed(18'(17'h10000 - {1'b0, wa}))
                   + 50'sd32768;
    assign blend_r = blend_s[47:16];

    // leash step with saturation; quotient never exceeds |d|
    always_comb
    begin
        if (state_reg == S_DIVX)
        begin
            mv_sum = dx_reg[31] ? 33'(lx_reg) - 33'(unit_q)
                                : 33'(lx_reg) + 33'(unit_q);
        end
        else
        begin
            mv_sum = dy_reg[31] ? 33'(ly_reg) - 33'(unit_q)
                                : 33'(ly_reg) + 33'(unit_q);
        end
    end
    assign mv_sat = sat33(mv_sum);

    always_comb
    begin
        job = '0;
        if (!unit_started_reg)
        begin
            unique case (state_reg)
                S_SQRT:  begin job.start = 1'b1; job.is_div = 1'b0; job.num = acc_reg; end
                S_DIVX, S_DIVY:
                begin
                    job.start = 1'b1;
                    job.is_div = 1'b1;
                    job.num = acc_reg;
                    job.den = dist_reg;
                end
                default: job = '0;
            endcase
        end
    end

    lpls_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job),
        .busy   (unit_busy),
        .result (unit_q)
    );

    logic unit_done;
    assign unit_done = unit_started_reg && !unit_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            radius_reg <= RADIUS_RESET;
            weight_reg <= WEIGHT_RESET;
            sx_reg <= '0;
            sy_reg <= '0;
            lx_reg <= '0;
            ly_reg <= '0;
            tx_reg <= '0;
            ty_reg <= '0;
            tip_reg <= 1'b0;
            dx_reg <= '0;
            dy_reg <= '0;
            acc_reg <= '0;
            dist_reg <= '0;
            excess_reg <= '0;
            latched_reg <= 1'b0;
            ptip_reg <= 1'b0;
            unit_started_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_RADIUS)
                begin
                    radius_reg <= cfg_data;
                end
                else
                begin
                    weight_reg <= cfg_data[WEIGHT_W-1:0];
                end
            end
            // raise valid for a new word, drop it once the old one is taken
            if (state_reg == S_OUT && (!ovalid_reg || out_ready))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        tx_reg <= in_word.target_x;
                        ty_reg <= in_word.target_y;
                        tip_reg <= in_word.buttons[0];
                        unique case (cmd_t'(in_word.cmd))
                            CMD_REPORT:
                            begin
                                if (radius_reg <= RADIUS_BYPASS)
                                begin
                                    sx_reg <= in_word.target_x;
                                    sy_reg <= in_word.target_y;
                                    lx_reg <= in_word.target_x;
                                    ly_reg <= in_word.target_y;
                                    state_reg <= S_OUT;
                                end
                                else if (!latched_reg || (in_word.buttons[0] && !ptip_reg))
                                begin
                                    sx_reg <= in_word.target_x;
                                    sy_reg <= in_word.target_y;
                                    lx_reg <= in_word.target_x;
                                    ly_reg <= in_word.target_y;
                                    latched_reg <= 1'b1;
                                    ptip_reg <= in_word.buttons[0];
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_DIFF;
                                end
                            end
                            CMD_RESET:
                            begin
                                sx_reg <= in_word.target_x;
                                sy_reg <= in_word.target_y;
                                lx_reg <= in_word.target_x;
                                ly_reg <= in_word.target_y;
                                latched_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            CMD_SETPOS:
                            begin
                                sx_reg <= in_word.target_x;
                                sy_reg <= in_word.target_y;
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_DIFF:
                begin
                    dx_reg <= dx_sat;
                    dy_reg <= dy_sat;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    acc_reg <= 66'(mul_p);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    acc_reg <= acc_reg + 66'(mul_p);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (unit_done)
                    begin
                        unit_started_reg <= 1'b0;
                        dist_reg <= unit_q;
                        excess_reg <= unit_q - 33'(radius_reg);
                        if (unit_q > 33'(radius_reg))
                        begin
                            state_reg <= S_MULX;
                        end
                        else
                        begin
                            state_reg <= S_BLX;
                        end
                    end
                    else
                    begin
                        unit_started_reg <= 1'b1;
                    end
                end
                S_MULX:
                begin
                    acc_reg <= 66'(mul_p);
                    state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (unit_done)
                    begin
                        unit_started_reg <= 1'b0;
                        lx_reg <= mv_sat;
                        state_reg <= S_MULY;
                    end
                    else
                    begin
                        unit_started_reg <= 1'b1;
                    end
                end
                S_MULY:
                begin
                    acc_reg <= 66'(mul_p);
                    state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (unit_done)
                    begin
                        unit_started_reg <= 1'b0;
                        ly_reg <= mv_sat;
                        state_reg <= S_BLX;
                    end
                    else
                    begin
                        unit_started_reg <= 1'b1;
                    end
                end
                S_BLX:
                begin
                    sx_reg <= blend_r;
                    state_reg <= S_BLY;
                end
                S_BLY:
                begin
                    sy_reg <= blend_r;
                    ptip_reg <= tip_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            out_reg.pos_x <= sx_reg;
            out_reg.pos_y <= sy_reg;
        end
    end

    // next item may enter while the last result still waits
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_word = out_reg;
endmodule

// File: rtl/core/lpls_unit.sv
// ----------------------------------------------------------------------------
// lpls_unit
// Shared bit-serial unit: restoring square root or restoring division,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module lpls_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  lpls_pkg::job_t  job,
    output logic            busy,
    output logic [32:0]     result
);
    import lpls_pkg::*;

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [65:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [35:0] rem_reg, rem_next;
    logic [32:0] q_reg, q_next;
    logic [35:0] trial;
    logic [35:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        shifted = '0;
        trial = '0;
        if (job.start)
        begin
            busy_next = 1'b1;
            div_next = job.is_div;
            num_next = job.num;
            den_next = job.den;
            rem_next = '0;
            q_next = '0;
            cnt_next = job.is_div ? 7'd66 : 7'd33;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // quotient < 2^33 and remainder < den, so 34 bits suffice
                shifted = {rem_reg[34:0], num_reg[65]};
                trial = shifted - {3'b0, den_reg};
                num_next = {num_reg[64:0], 1'b0};
                if (!trial[35])
                begin
                    rem_next = trial;
                    q_next = {q_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    q_next = {q_reg[31:0], 1'b0};
                end
            end
            else
            begin
                // digit-by-digit square root, two radicand bits per step
                shifted = {rem_reg[33:0], num_reg[65:64]};
                trial = shifted - {1'b0, q_reg, 2'b01};
                num_next = {num_reg[63:0], 2'b00};
                if (!trial[35])
                begin
                    rem_next = trial;
                    q_next = {q_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    q_next = {q_reg[31:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            div_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end

    assign busy = busy_reg;
    assign result = q_reg;
endmodule

// File: rtl/core/lpls_checker.sv
// ----------------------------------------------------------------------------
// lpls_checker
// Port-level checks of the leash smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "lazy_pointer_leash_smoother_macros.svh"
module lpls_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] out_word
);
    `LPLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `LPLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
    `LPLS_ASSERT_NEXT(a_no_out_while_accept, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)
endmodule

bind lazy_pointer_leash_smoother lpls_checker u_lpls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

// File: bench/lazy_pointer_leash_smoother_test.sv
// ----------------------------------------------------------------------------
// lazy_pointer_leash_smoother_test
// Self-checking bench for the leash smoother. The bench drives pen reports
// through the valid/ready input, stalls the output at random, and sweeps the
// radius and weight registers across their extremes. A scoreboard keeps its
// own model of the leash, the smoothed point and the latch flags. It predicts
// each smoothed position and compares it with what the block returns.
// ----------------------------------------------------------------------------
module lazy_pointer_leash_smoother_test;
    import lpls_pkg::*;

    // Keeps the leash model and the queue of positions still to come back.
    class leash_scoreboard;
        logic [22:0]        radius;
        logic [15:0]        weight;
        logic signed [31:0] pos_x, pos_y, cur_x, cur_y;
        bit                 latched, prev_tip;
        out_word_t          pending_pos[$];
        int                 errors;

        function new();
            radius = RADIUS_RESET;
            weight = WEIGHT_RESET;
            pos_x = 0;
            pos_y = 0;
            cur_x = 0;
            cur_y = 0;
            latched = 0;
            prev_tip = 0;
            errors = 0;
        endfunction

        function logic signed [31:0] clip(logic signed [63:0] v);
            if (v > 64'sd2147483647)
                return 32'h7fffffff;
            if (v < -64'sd2147483648)
                return 32'h80000000;
            return v[31:0];
        endfunction

        function logic [31:0] root(logic [63:0] v);
            logic [31:0] r;
            logic [31:0] c;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (32'd1 << b);
                if ({32'd0, c} * {32'd0, c} <= v)
                    r = c;
            end
            return r;
        endfunction

        // Pull one axis of the leash toward the target by its share of the excess.
        function logic signed [31:0] pull(logic signed [31:0] c, logic signed [63:0] d,
                                          logic [63:0] excess, logic [63:0] reach);
            logic [127:0] m;
            logic [63:0]  dm;
            dm = d < 0 ? -d : d;
            m = ({64'd0, dm} * {64'd0, excess}) / {64'd0, reach};
            if (d < 0)
                return clip(64'(c) - $signed(m[63:0]));
            return clip(64'(c) + $signed(m[63:0]));
        endfunction

        function logic signed [31:0] mix(logic signed [31:0] p, logic signed [31:0] c,
                                         logic [16:0] a);
            logic signed [63:0] s;
            s = 64'(p) * $signed({47'd0, a}) + 64'(c) * $signed({47'd0, 17'd65536 - a});
            s = (s + 64'sd32768) >>> 16;
            return s[31:0];
        endfunction

        function void report(logic signed [31:0] tx, logic signed [31:0] ty, bit tip);
            logic signed [63:0] dx, dy;
            logic [63:0]        sq, reach;
            logic [16:0]        a;
            if (radius <= RADIUS_BYPASS)
            begin
                pos_x = tx;
                cur_x = tx;
                pos_y = ty;
                cur_y = ty;
                return;
            end
            if (!latched || (tip && !prev_tip))
            begin
                pos_x = tx;
                cur_x = tx;
                pos_y = ty;
                cur_y = ty;
                latched = 1;
                prev_tip = tip;
                return;
            end
            dx = clip(64'(tx) - 64'(cur_x));
            dy = clip(64'(ty) - 64'(cur_y));
            sq = dx * dx + dy * dy;
            reach = root(sq);
            if (reach > radius)
            begin
                cur_x = pull(cur_x, dx, reach - radius, reach);
                cur_y = pull(cur_y, dy, reach - radius, reach);
            end
            a = weight > WEIGHT_MAX ? WEIGHT_MAX : weight;
            pos_x = mix(pos_x, cur_x, a);
            pos_y = mix(pos_y, cur_y, a);
            prev_tip = tip;
        endfunction

        function void note_input(in_word_t w);
            out_word_t e;
            case (cmd_t'(w.cmd))
                CMD_REPORT: report(w.target_x, w.target_y, w.buttons[0]);
                CMD_RESET:
                begin
                    pos_x = w.target_x;
                    cur_x = w.target_x;
                    pos_y = w.target_y;
                    cur_y = w.target_y;
                    latched = 1;
                end
                CMD_SETPOS:
                begin
                    pos_x = w.target_x;
                    pos_y = w.target_y;
                end
                default: ;
            endcase
            e.pos_x = pos_x;
            e.pos_y = pos_y;
            pending_pos.push_back(e);
        endfunction

        function void check_output(out_word_t got);
            out_word_t e;
            if (pending_pos.size() == 0)
            begin
                $display("%0t: unexpected word, got x=%h y=%h", $time, got.pos_x, got.pos_y);
                errors++;
                return;
            end
            e = pending_pos.pop_front();
            if (got.pos_x !== e.pos_x)
            begin
                $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== e.pos_y)
            begin
                $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, got.pos_y);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_word_t   out_word;
    logic        cfg_we = 0;
    logic        cfg_idx = 0;
    logic [22:0] cfg_data = 0;

    leash_scoreboard board = new();
    bit              quiet = 0;     // no idling on either side
    bit              hold_req = 0;  // ask the receiver for a long hold-off
    bit              in_dropped = 1; // in_valid already driven low
    logic signed [31:0] last_x = 0, last_y = 0;

    lazy_pointer_leash_smoother uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4000000;
        $display("lazy_pointer_leash_smoother_test NOT OK");
        $finish;
    end

    // Receiver: check each accepted word, then pick the next ready level.
    // Stalls come in bursts; a hold-off request stalls for a long stretch so
    // the block backs up into its input.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_output(out_word);
            if (hold_req)
            begin
                hold_req = 0;
                stall = 600;
            end
            else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 13);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    // Drop the input valid once, unless it is already low.
    task automatic drop_valid();
        if (!in_dropped)
        begin
            in_valid <= 0;
            in_dropped = 1;
        end
    endtask

    // Offer one word and hold it until accepted; maybe idle afterwards.
    task automatic send_word(logic [1:0] cmd, logic signed [31:0] x,
                             logic signed [31:0] y, logic [7:0] buttons);
        in_word_t w;
        w.cmd = cmd;
        w.target_x = x;
        w.target_y = y;
        w.buttons = buttons;
        in_valid <= 1;
        in_dropped = 0;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(w);
        last_x = x;
        last_y = y;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            drop_valid();
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Drain all pending positions, then write a register while the block is idle.
    task automatic write_reg(reg_idx_t idx, logic [22:0] data);
        drop_valid();
        while (board.pending_pos.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_RADIUS)
            board.radius = data;
        else
            board.weight = data[15:0];
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base);
        logic signed [63:0] v;
        int unsigned        span;
        span = 1 << $urandom_range(4, 24);
        v = 64'(base) + $signed(64'($urandom_range(0, span))) - $signed(64'(span / 2));
        return board.clip(v);
    endfunction

    function automatic logic signed [31:0] any_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
    endfunction

    // Random pen traffic: mostly reports that drift near the last point,
    // with commands and far jumps mixed in.
    task automatic random_items(int count);
        int unsigned pick;
        logic [1:0]  cmd;
        logic [7:0]  buttons;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            cmd = pick < 80 ? CMD_REPORT : pick < 88 ? CMD_RESET :
                  pick < 95 ? CMD_SETPOS : CMD_NONE;
            buttons = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
                buttons[0] = board.prev_tip;
            if ($urandom_range(0, 4) != 0)
                send_word(cmd, near(last_x), near(last_y), buttons);
            else
                send_word(cmd, any_coord(), any_coord(), buttons);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: first report snaps, then tracking and edge cases.
        send_word(CMD_REPORT, 32'sd100000, -32'sd100000, 8'h00);
        send_word(CMD_REPORT, 32'sd400000, -32'sd100000, 8'h00);
        send_word(CMD_REPORT, 32'sd410000, -32'sd90000, 8'h00);
        send_word(CMD_REPORT, 32'h7fffffff, 32'h7fffffff, 8'hfe);
        send_word(CMD_REPORT, 32'h80000000, 32'h80000000, 8'h00);
        send_word(CMD_REPORT, 32'h80000000, 32'h7fffffff, 8'h00);
        send_word(CMD_REPORT, 32'sd0, 32'sd0, 8'h01);       // tip goes down: snap
        send_word(CMD_REPORT, 32'sd500000, 32'sd0, 8'hff);  // tip held
        send_word(CMD_REPORT, 32'sd500000, 32'sd0, 8'h00);  // tip lifts
        send_word(CMD_RESET, 32'h7fffffff, 32'h80000000, 8'h01);
        send_word(CMD_REPORT, 32'h80000000, 32'h7fffffff, 8'h01);
        send_word(CMD_SETPOS, -32'sd123456, 32'sd654321, 8'haa);
        send_word(CMD_REPORT, 32'sd1000000, 32'sd1000000, 8'h00);
        send_word(CMD_NONE, 32'sd5, 32'sd5, 8'hff);
        send_word(CMD_REPORT, 32'sd1000001, 32'sd1000001, 8'h00);

        // Back up the block: long receiver hold-off while words keep coming.
        hold_req = 1;
        random_items(30);

        write_reg(REG_RADIUS, 23'd0);
        write_reg(REG_WEIGHT, 23'd0);
        random_items(100);
        write_reg(REG_RADIUS, 23'd655);
        write_reg(REG_WEIGHT, 23'd65535);
        random_items(100);
        write_reg(REG_RADIUS, 23'd656);
        random_items(150);
        write_reg(REG_WEIGHT, 23'd62259);
        write_reg(REG_RADIUS, 23'd6553600);
        random_items(150);
        write_reg(REG_WEIGHT, 23'd62260);
        write_reg(REG_RADIUS, 23'h7fffff);
        random_items(150);
        write_reg(REG_RADIUS, 23'($urandom_range(656, 200000)));
        write_reg(REG_WEIGHT, 23'($urandom));
        random_items(200);
        write_reg(REG_RADIUS, RADIUS_RESET);
        write_reg(REG_WEIGHT, 23'd1);
        random_items(150);

        // Final stretch runs flat out with no idling.
        quiet = 1;
        write_reg(REG_WEIGHT, 23'(WEIGHT_RESET));
        random_items(200);
        drop_valid();

        while (board.pending_pos.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.pending_pos.size() != 0)
            board.errors++;
        if (board.errors == 0)
            $display("lazy_pointer_leash_smoother_test OK");
        else
            $display("lazy_pointer_leash_smoother_test NOT OK");
        $finish;
    end
endmodule

// File: lazy_pointer_leash_smoother.f
+incdir+rtl/core
rtl/core/lpls_pkg.sv
rtl/core/lpls_unit.sv
rtl/core/lazy_pointer_leash_smoother.sv
rtl/core/lpls_checker.sv
bench/lazy_pointer_leash_smoother_test.sv
